[rtl/core/link_ping_echo_latency_monitor_macros.svh]
// Assertion helpers for the checker file of this block.
`ifndef LINK_PING_ECHO_LATENCY_MONITOR_MACROS_SVH
`define LINK_PING_ECHO_LATENCY_MONITOR_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define LPELM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("link monitor check failed");

// Next-cycle implication, checked while reset is released.
`define LPELM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("link monitor check failed");

`endif

[rtl/core/lpelm_pkg.sv]
`timescale 1ns / 1ps

package lpelm_pkg;

	localparam int WORD_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 32;
	localparam int HIDX_W  = 6;
	localparam int THR_W   = 8;
	localparam int STATE_W = 3;

	// Ping slots must be a power of two: the slot is the low bits of the ping number.
	localparam int PING_SLOTS = 64;
	localparam int SLOT_W     = $clog2(PING_SLOTS);

	localparam int HIST_LEN = 40;
	localparam int HIST_W   = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
	localparam int SUM_W    = ((HIST_W > HIDX_W) ? HIST_W : HIDX_W) + 1;

	// A round trip counts only below 2**RT_W frames.
	localparam int RT_W = 6;

	localparam logic [BYTE_W-1:0] NO_WORD       = 8'hFF;
	localparam logic [THR_W-1:0]  THR_RESET     = 8'd30;

	typedef enum logic [STATE_W-1:0] {
		ST_IDLE   = 3'd0,
		ST_SEND   = 3'd1,
		ST_WAIT   = 3'd2,
		ST_GOT    = 3'd3,
		ST_RECV   = 3'd4,
		ST_ECHO   = 3'd5,
		ST_NOLINK = 3'd6
	} state_t;

	function automatic state_t expect_of(input logic master, input state_t s);
		state_t r;
		r = ST_IDLE;
		if (master) begin
			case (s)
				ST_SEND:   r = ST_RECV;
				ST_GOT:    r = ST_ECHO;
				ST_NOLINK: r = ST_NOLINK;
				default:   r = ST_IDLE;
			endcase
		end else begin
			case (s)
				ST_RECV:   r = ST_SEND;
				ST_ECHO:   r = ST_WAIT;
				ST_NOLINK: r = ST_NOLINK;
				default:   r = ST_IDLE;
			endcase
		end
		return r;
	endfunction

endpackage

[rtl/core/lpelm_ram.sv]
`timescale 1ns / 1ps

module lpelm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/link_ping_echo_latency_monitor.sv]
`timescale 1ns / 1ps

// Ping/echo link monitor. One item (a frame tick) can be accepted in every cycle. Its result
// passes through the first register and then the second, which drives the outputs. The first
// register holds the item together with the send-frame read from the ping slot memory. The
// second holds the result together with the history ring read. Input stalls only when both
// registers are full and out_ready is low. Both memories have a valid bit per entry cleared
// by reset, so the block is ready right after reset with no clearing pass. The no-link
// threshold may be written at any time the block is idle.
module link_ping_echo_latency_monitor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lpelm_pkg::THR_W-1:0]    cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           master_mode,
	input  logic [lpelm_pkg::WORD_W-1:0]   rx_word,
	input  logic                           link_busy,
	input  logic [lpelm_pkg::HIDX_W-1:0]   history_index,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [lpelm_pkg::WORD_W-1:0]   tx_word,
	output logic [lpelm_pkg::STATE_W-1:0]  shown_state,
	output logic [lpelm_pkg::BYTE_W-1:0]   partner_status,
	output logic [lpelm_pkg::STATE_W-1:0]  expected_state,
	output logic [lpelm_pkg::CNT_W-1:0]    latency,
	output logic [lpelm_pkg::CNT_W-1:0]    latency_best,
	output logic [lpelm_pkg::CNT_W-1:0]    latency_worst,
	output logic [lpelm_pkg::CNT_W-1:0]    tx_total,
	output logic [lpelm_pkg::CNT_W-1:0]    rx_total,
	output logic [lpelm_pkg::CNT_W-1:0]    stall_frames,
	output logic [lpelm_pkg::CNT_W-1:0]    frame_total,
	output logic [lpelm_pkg::BYTE_W-1:0]   history_value
);
	import lpelm_pkg::*;

	// Configuration and monitor state.
	logic [THR_W-1:0]   thr_q;
	logic [CNT_W-1:0]   frame_q, stall_q, txc_q, rxc_q, lpf_q;
	logic [BYTE_W-1:0]  ping_q, lps_q, echo_q, partner_q;
	logic [RT_W-1:0]    rt_last_q, rt_best_q, rt_worst_q;
	logic [CNT_W-1:0]   gap_last_q, gap_best_q, gap_worst_q;
	state_t             own_q;
	logic [HIST_W-1:0]  hpos_q;
	logic [PING_SLOTS-1:0] slot_vld_q;
	logic [HIST_LEN-1:0]   hist_vld_q;

	// Input stage.
	logic               s1_v;
	logic               master_mode_s1, link_busy_s1;
	logic [WORD_W-1:0]  rx_word_s1;
	logic [HIDX_W-1:0]  history_index_s1;
	logic               sf_byp_s1;
	logic [WORD_W-1:0]  sf_byp_data_s1;

	// Result stage.
	logic               s2_v;
	logic [WORD_W-1:0]  tx_word_s2;
	state_t             shown_s2, expect_s2;
	logic [BYTE_W-1:0]  peer_s2;
	logic [CNT_W-1:0]   lat_s2, best_s2, worst_s2, txc_s2, rxc_s2, stall_s2, frame_s2;
	logic               hist_oor_s2, hist_byp_s2, hist_vld_s2;
	logic [BYTE_W-1:0]  hist_byp_data_s2;

	logic               acc, adv1;
	logic [SLOT_W-1:0]  sf_raddr, sf_waddr;
	logic               sf_we;
	logic [WORD_W-1:0]  sf_rdata, sf_data, rt_diff;
	logic [BYTE_W-1:0]  hist_rdata;

	// Next-state values.
	logic [BYTE_W-1:0]  hi, lo;
	logic               echo_ok, new_ping;
	logic [CNT_W-1:0]   fc_n, sc_n, txc_n, rxc_n, lpf_n, gap;
	logic [BYTE_W-1:0]  ping_n, lps_n, echo_n, partner_n;
	logic [RT_W-1:0]    rt, rt_last_n, rt_best_n, rt_worst_n;
	logic [CNT_W-1:0]   gap_last_n, gap_best_n, gap_worst_n;
	state_t             st, own_n, expect_w;
	logic [WORD_W-1:0]  tx_w;
	logic [CNT_W-1:0]   lat_w, best_w, worst_w;
	logic               hist_we;
	logic [BYTE_W-1:0]  hist_wdata;
	logic [HIST_W-1:0]  hpos_n, hist_raddr;
	logic [SUM_W-1:0]   hsum;
	logic               hist_oor;

	assign adv1     = s1_v && (!s2_v || out_ready);
	assign in_ready = !s1_v || adv1;
	assign acc      = in_valid && in_ready;

	assign sf_raddr = rx_word[BYTE_W +: SLOT_W];
	assign sf_we    = adv1 && master_mode_s1;
	assign sf_waddr = ping_n[SLOT_W-1:0];

	lpelm_ram #(.WIDTH(WORD_W), .DEPTH(PING_SLOTS)) u_send_ram (
		.clk   (clk),
		.we    (sf_we),
		.waddr (sf_waddr),
		.wdata (fc_n[WORD_W-1:0]),
		.re    (acc),
		.raddr (sf_raddr),
		.rdata (sf_rdata)
	);

	// A send frame written by the item leaving stage one in the same cycle is not yet
	// in the memory read data.
	assign sf_data = sf_byp_s1 ? sf_byp_data_s1 : sf_rdata;

	assign hi      = rx_word_s1[WORD_W-1 -: BYTE_W];
	assign lo      = rx_word_s1[BYTE_W-1:0];
	assign fc_n    = frame_q + CNT_W'(1);
	assign rt_diff = fc_n[WORD_W-1:0] - sf_data;
	assign rt      = rt_diff[RT_W-1:0];
	assign echo_ok = (hi != NO_WORD) && slot_vld_q[hi[SLOT_W-1:0]] && (hi != echo_q)
		&& (rt_diff[WORD_W-1:RT_W] == '0);
	assign new_ping = (hi != NO_WORD) && (hi != lps_q);
	assign gap      = fc_n - lpf_q;

	always_comb begin
		sc_n        = stall_q + CNT_W'(1);
		txc_n       = txc_q;
		rxc_n       = rxc_q;
		lpf_n       = lpf_q;
		ping_n      = ping_q;
		lps_n       = lps_q;
		echo_n      = echo_q;
		partner_n   = lo;
		rt_last_n   = rt_last_q;
		rt_best_n   = rt_best_q;
		rt_worst_n  = rt_worst_q;
		gap_last_n  = gap_last_q;
		gap_best_n  = gap_best_q;
		gap_worst_n = gap_worst_q;
		st          = own_q;
		own_n       = own_q;
		hist_we     = 1'b0;
		hist_wdata  = '0;
		tx_w        = '0;
		if (master_mode_s1) begin
			if (hi == NO_WORD) begin
				partner_n = BYTE_W'(ST_IDLE);
			end
			if (link_busy_s1) begin
				st = ST_WAIT;
			end
			if (echo_ok) begin
				rt_last_n = rt;
				if (rt_best_q == '0 || rt < rt_best_q) begin
					rt_best_n = rt;
				end
				if (rt > rt_worst_q) begin
					rt_worst_n = rt;
				end
				hist_we    = 1'b1;
				hist_wdata = BYTE_W'(rt);
				echo_n     = hi;
				rxc_n      = rxc_q + CNT_W'(1);
				sc_n       = '0;
				st         = ST_GOT;
			end
			if (sc_n > CNT_W'(thr_q)) begin
				st = ST_NOLINK;
			end
			// The ping number wraps and never uses zero.
			ping_n = ping_q + BYTE_W'(1);
			if (ping_n == '0) begin
				ping_n = BYTE_W'(1);
			end
			tx_w  = {ping_n, BYTE_W'(ST_SEND)};
			txc_n = txc_q + CNT_W'(1);
			own_n = ST_SEND;
		end else begin
			if (new_ping) begin
				// The first ping after reset has no earlier arrival to measure from.
				if (lps_q != '0) begin
					gap_last_n = gap;
					if (gap_best_q == '0 || gap < gap_best_q) begin
						gap_best_n = gap;
					end
					if (gap > gap_worst_q) begin
						gap_worst_n = gap;
					end
					hist_we    = 1'b1;
					hist_wdata = gap[BYTE_W-1:0];
				end
				lps_n = hi;
				lpf_n = fc_n;
				rxc_n = rxc_q + CNT_W'(1);
				sc_n  = '0;
				st    = ST_ECHO;
				tx_w  = {hi, BYTE_W'(ST_ECHO)};
				txc_n = txc_q + CNT_W'(1);
			end else begin
				tx_w = {lps_q, BYTE_W'(own_q)};
			end
			if (sc_n > CNT_W'(thr_q)) begin
				st = ST_NOLINK;
			end
			own_n = st;
		end
		expect_w = expect_of(master_mode_s1, st);
		if (master_mode_s1) begin
			lat_w   = CNT_W'(rt_last_n);
			best_w  = CNT_W'(rt_best_n);
			worst_w = CNT_W'(rt_worst_n);
		end else begin
			lat_w   = gap_last_n;
			best_w  = gap_best_n;
			worst_w = gap_worst_n;
		end
	end

	// History read position: oldest entry is at the write position after this update.
	always_comb begin
		hpos_n = hpos_q;
		if (hist_we) begin
			hpos_n = (hpos_q == HIST_W'(HIST_LEN - 1)) ? '0 : hpos_q + HIST_W'(1);
		end
		hsum       = SUM_W'(hpos_n) + SUM_W'(history_index_s1);
		hist_oor   = SUM_W'(history_index_s1) >= SUM_W'(HIST_LEN);
		hist_raddr = (hsum >= SUM_W'(HIST_LEN)) ? HIST_W'(hsum - SUM_W'(HIST_LEN))
			: HIST_W'(hsum);
	end

	lpelm_ram #(.WIDTH(BYTE_W), .DEPTH(HIST_LEN)) u_hist_ram (
		.clk   (clk),
		.we    (adv1 && hist_we),
		.waddr (hpos_q),
		.wdata (hist_wdata),
		.re    (adv1),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_RESET;
			s1_v        <= 1'b0;
			s2_v        <= 1'b0;
			frame_q     <= '0;
			stall_q     <= '0;
			txc_q       <= '0;
			rxc_q       <= '0;
			lpf_q       <= '0;
			ping_q      <= '0;
			lps_q       <= '0;
			echo_q      <= '0;
			partner_q   <= BYTE_W'(ST_IDLE);
			rt_last_q   <= '0;
			rt_best_q   <= '0;
			rt_worst_q  <= '0;
			gap_last_q  <= '0;
			gap_best_q  <= '0;
			gap_worst_q <= '0;
			own_q       <= ST_IDLE;
			hpos_q      <= '0;
			slot_vld_q  <= '0;
			hist_vld_q  <= '0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (in_ready) begin
				s1_v <= in_valid;
			end
			if (adv1) begin
				s2_v <= 1'b1;
			end else if (out_ready) begin
				s2_v <= 1'b0;
			end
			if (adv1) begin
				frame_q     <= fc_n;
				stall_q     <= sc_n;
				txc_q       <= txc_n;
				rxc_q       <= rxc_n;
				lpf_q       <= lpf_n;
				ping_q      <= ping_n;
				lps_q       <= lps_n;
				echo_q      <= echo_n;
				partner_q   <= partner_n;
				rt_last_q   <= rt_last_n;
				rt_best_q   <= rt_best_n;
				rt_worst_q  <= rt_worst_n;
				gap_last_q  <= gap_last_n;
				gap_best_q  <= gap_best_n;
				gap_worst_q <= gap_worst_n;
				own_q       <= own_n;
				hpos_q      <= hpos_n;
				if (master_mode_s1) begin
					slot_vld_q[sf_waddr] <= 1'b1;
				end
				if (hist_we) begin
					hist_vld_q[hpos_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			master_mode_s1   <= master_mode;
			rx_word_s1       <= rx_word;
			link_busy_s1     <= link_busy;
			history_index_s1 <= history_index;
			sf_byp_s1        <= sf_we && (sf_waddr == sf_raddr);
			sf_byp_data_s1   <= fc_n[WORD_W-1:0];
		end
		if (adv1) begin
			tx_word_s2       <= tx_w;
			shown_s2         <= st;
			expect_s2        <= expect_w;
			peer_s2          <= partner_n;
			lat_s2           <= lat_w;
			best_s2          <= best_w;
			worst_s2         <= worst_w;
			txc_s2           <= txc_n;
			rxc_s2           <= rxc_n;
			stall_s2         <= sc_n;
			frame_s2         <= fc_n;
			hist_oor_s2      <= hist_oor;
			hist_byp_s2      <= hist_we && (hpos_q == hist_raddr);
			hist_byp_data_s2 <= hist_wdata;
			hist_vld_s2      <= hist_vld_q[hist_raddr];
		end
	end

	assign out_valid      = s2_v;
	assign tx_word        = tx_word_s2;
	assign shown_state    = shown_s2;
	assign partner_status = peer_s2;
	assign expected_state = expect_s2;
	assign latency        = lat_s2;
	assign latency_best   = best_s2;
	assign latency_worst  = worst_s2;
	assign tx_total       = txc_s2;
	assign rx_total       = rxc_s2;
	assign stall_frames   = stall_s2;
	assign frame_total    = frame_s2;
	assign history_value  = hist_oor_s2 ? '0
		: hist_byp_s2 ? hist_byp_data_s2
		: hist_vld_s2 ? hist_rdata : '0;

endmodule

[rtl/core/lpelm_chk.sv]
`timescale 1ns / 1ps
`include "link_ping_echo_latency_monitor_macros.svh"

module lpelm_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [lpelm_pkg::WORD_W-1:0]   tx_word,
	input logic [lpelm_pkg::STATE_W-1:0]  shown_state,
	input logic [lpelm_pkg::STATE_W-1:0]  expected_state,
	input logic [lpelm_pkg::CNT_W-1:0]    latency,
	input logic [lpelm_pkg::CNT_W-1:0]    latency_worst,
	input logic [lpelm_pkg::CNT_W-1:0]    stall_frames
);
	import lpelm_pkg::*;

	logic xfer_done;
	logic stall_zero;

	assign xfer_done  = (shown_state == ST_GOT) || (shown_state == ST_ECHO);
	assign stall_zero = out_valid && (stall_frames == '0);

	// A result that waits keeps its valid and its word.
	`LPELM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(tx_word))

	// A stall count of zero only follows a completed transfer in this frame.
	`LPELM_ASSERT_NOW(a_stall_zero, clk, arst_n, stall_zero, xfer_done)

	// No-link is mirrored by the expected partner state in both roles.
	`LPELM_ASSERT_NOW(a_nolink_expect, clk, arst_n, out_valid && shown_state == ST_NOLINK, expected_state == ST_NOLINK)

	// The last latency never exceeds the worst one of the same role.
	`LPELM_ASSERT_NOW(a_worst_bound, clk, arst_n, out_valid, latency <= latency_worst)

endmodule

bind link_ping_echo_latency_monitor lpelm_chk u_lpelm_chk (.*);
